// ----- rtl/core/fccr_pkg.sv -----
// Package for the FAT32 cluster chain reader.
// Holds the beat types, item kind codes, register indexes and fixed constants.
// No dependencies; every module of the block refers to it by scoped names.
package fccr_pkg;

   // Default allocation table depth, in entries.
   localparam int TABLE_DEPTH_DEF = 4096;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Fixed file system constants.
   localparam logic [27:0] END_MARK           = 28'hFFFFFF8;
   localparam logic [9:0]  SECTOR_BYTES       = 10'd512;
   localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
   localparam logic [31:0] PART_OFFSET_RESET  = 32'd2048;
   localparam logic [31:0] DATA_START_RESET   = 32'd0;
   localparam logic [7:0]  SPC_RESET          = 8'd1;
   localparam logic [7:0]  SPC_MIN            = 8'd1;
   localparam logic [7:0]  SPC_MAX            = 8'd128;

   // Item kinds, also used as the queued operation codes.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_OPEN = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PART_OFFSET     = 2'd0;
   localparam logic [1:0] CSR_DATA_START      = 2'd1;
   localparam logic [1:0] CSR_CLUSTER_SECTORS = 2'd2;

   // Input beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] table_index;
      logic [31:0] table_value;
      logic [27:0] start_cluster;
      logic [31:0] length_bytes;
      logic        opens_directory;
      logic        opens_root;
      logic [9:0]  chunk_bytes;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [31:0] read_sector;
      logic [8:0]  sector_offset;
      logic [9:0]  bytes_taken;
      logic        load_next;
      logic [31:0] next_sector;
      logic        chain_end;
      logic [31:0] file_offset;
   } rsp_type;

   // Classified command held in the queue.
   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] table_index;
      logic [27:0] entry;
      logic [27:0] start_cluster;
      logic [31:0] length_bytes;
      logic        opens_directory;
      logic        opens_root;
      logic [9:0]  chunk_bytes;
   } cmd_type;

   // Geometry handed from the register file to the back end.
   typedef struct packed {
      logic [31:0] base_sector;
      logic [7:0]  spc;
   } cfg_type;

endpackage

// ----- rtl/core/fccr_front.sv -----
// Front end of the FAT32 cluster chain reader: classifies an input beat.
// Depends on fccr_pkg for the beat and command types and the kind codes.
module fccr_front #(
   parameter int TABLE_DEPTH = fccr_pkg::TABLE_DEPTH_DEF
) (
   input  fccr_pkg::req_type req_item,
   output fccr_pkg::cmd_type cmd
);

   localparam logic [31:0] DEPTH_WORD = 32'(TABLE_DEPTH);

   logic in_table;

   // A table load beyond the table depth is turned into a no-op.
   assign in_table = 32'(req_item.table_index) < DEPTH_WORD;

   // Build the queued command; table entries are cut to 28 bits here.
   always_comb begin
      cmd.table_index     = req_item.table_index;
      cmd.entry           = req_item.table_value[27:0];
      cmd.start_cluster   = req_item.start_cluster;
      cmd.length_bytes    = req_item.length_bytes;
      cmd.opens_directory = req_item.opens_directory;
      cmd.opens_root      = req_item.opens_root;
      cmd.chunk_bytes     = req_item.chunk_bytes;
      unique case (req_item.kind)
         fccr_pkg::OP_LOAD: begin
            cmd.op = in_table ? fccr_pkg::OP_LOAD : fccr_pkg::OP_NONE;
         end
         fccr_pkg::OP_OPEN: begin
            cmd.op = fccr_pkg::OP_OPEN;
         end
         fccr_pkg::OP_READ: begin
            cmd.op = fccr_pkg::OP_READ;
         end
         default: begin
            cmd.op = fccr_pkg::OP_NONE;
         end
      endcase
   end

endmodule

// ----- rtl/core/fccr_queue.sv -----
// Short command queue between the front and back ends of the chain reader.
// Depends on fccr_pkg for the command type and the queue depth.
module fccr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fccr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output fccr_pkg::cmd_type head
);

   localparam int PW = (fccr_pkg::QUEUE_DEPTH > 1) ? $clog2(fccr_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(fccr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(fccr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(fccr_pkg::QUEUE_DEPTH);

   fccr_pkg::cmd_type slot_ff [fccr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = count_ff == FULL_COUNT;
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue slots carry payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/fccr_back.sv -----
// Back end of the FAT32 cluster chain reader: table, open file state, chain walk.
// Depends on fccr_pkg for the command, result and geometry types and constants.
module fccr_back #(
   parameter int TABLE_DEPTH = fccr_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fccr_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  fccr_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   output fccr_pkg::rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [31:0] DEPTH_WORD = 32'(TABLE_DEPTH);

   // Sequencer states.
   localparam logic [1:0] S_IDLE      = 2'd0;
   localparam logic [1:0] S_READ_STEP = 2'd1;
   localparam logic [1:0] S_EMIT_NEXT = 2'd2;

   // Allocation table; contents are undefined until loaded.
   logic [27:0] table_mem [TABLE_DEPTH];
   logic [27:0] rd_data_ff;
   logic        mem_we;
   logic [31:0] wr_word;
   logic [31:0] rd_word;

   // Sequencer and open file state.
   logic [1:0]  state_ff, state_in;
   logic [27:0] cur_cluster_ff, cur_cluster_in;
   logic [6:0]  sic_ff, sic_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] size_ff, size_in;
   logic        dir_ff, dir_in;
   logic        root_ff, root_in;
   logic        ended_ff, ended_in;

   // Per chunk working registers.
   logic [31:0] product_ff, product_in;
   logic [9:0]  taken_ff, taken_in;
   logic [8:0]  off_ff, off_in;
   logic        step_ff, step_in;
   logic [31:0] rs_ff, rs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   fccr_pkg::rsp_type rsp_ff, rsp_in;

   // Chunk arithmetic.
   logic [31:0] rem;
   logic        clip;
   logic [9:0]  count;
   logic [8:0]  pos_low;
   logic [9:0]  left;
   logic [9:0]  taken;
   logic [31:0] mul_a;
   logic [31:0] product;
   logic [31:0] rs_now;
   logic [7:0]  ns;
   logic [31:0] nsec_same;
   logic        cluster_wrap;
   logic        out_of_table;
   logic        next_end;

   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Clip the requested count to the bytes left (not for a directory of size zero) and to the current sector.
   assign rem     = size_ff - pos_ff;
   assign clip    = !dir_ff || (size_ff != '0);
   assign count   = (clip && (32'(head.chunk_bytes) > rem)) ? rem[9:0] : head.chunk_bytes;
   assign pos_low = pos_ff[8:0];
   assign left    = fccr_pkg::SECTOR_BYTES - 10'(pos_low);
   assign taken   = (count < left) ? count : left;

   // Shared cluster times sectors-per-cluster multiplier, registered into product_ff.
   assign product = mul_a * 32'(cfg.spc);

   // Sector step after a chunk finished its sector.
   assign rs_now       = cfg.base_sector + product_ff + 32'(sic_ff);
   assign ns           = {1'b0, sic_ff} + 8'd1;
   assign nsec_same    = cfg.base_sector + product_ff + 32'(ns);
   assign cluster_wrap = ns >= cfg.spc;
   assign out_of_table = 32'(cur_cluster_ff) >= DEPTH_WORD;
   assign next_end     = rd_data_ff >= fccr_pkg::END_MARK;

   assign wr_word = 32'(head.table_index);
   assign rd_word = 32'(cur_cluster_ff);

   // Next state of the sequencer and the file state.
   always_comb begin
      state_in       = state_ff;
      cur_cluster_in = cur_cluster_ff;
      sic_in         = sic_ff;
      pos_in         = pos_ff;
      size_in        = size_ff;
      dir_in         = dir_ff;
      root_in        = root_ff;
      ended_in       = ended_ff;
      product_in     = product_ff;
      taken_in       = taken_ff;
      off_in         = off_ff;
      step_in        = step_ff;
      rs_in          = rs_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      mul_a          = rd_word - fccr_pkg::FIRST_DATA_CLUSTER;
      mem_we         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  fccr_pkg::OP_LOAD: begin
                     mem_we                = 1'b1;
                     rsp_valid_in          = 1'b1;
                     rsp_in                = '0;
                     rsp_in.chain_end      = ended_ff;
                     rsp_in.file_offset    = pos_ff;
                  end
                  fccr_pkg::OP_OPEN: begin
                     mul_a          = 32'(head.start_cluster) - fccr_pkg::FIRST_DATA_CLUSTER;
                     product_in     = product;
                     cur_cluster_in = head.start_cluster;
                     sic_in         = '0;
                     pos_in         = '0;
                     size_in        = head.length_bytes;
                     dir_in         = head.opens_directory;
                     root_in        = head.opens_root;
                     ended_in       = 1'b0;
                     rs_in          = '0;
                     off_in         = '0;
                     taken_in       = '0;
                     state_in       = S_EMIT_NEXT;
                  end
                  fccr_pkg::OP_READ: begin
                     if (ended_ff) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in             = '0;
                        rsp_in.chain_end   = 1'b1;
                        rsp_in.file_offset = pos_ff;
                     end else begin
                        product_in = product;
                        taken_in   = taken;
                        off_in     = pos_low;
                        pos_in     = pos_ff + 32'(taken);
                        step_in    = taken == left;
                        state_in   = S_READ_STEP;
                     end
                  end
                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in             = '0;
                     rsp_in.chain_end   = ended_ff;
                     rsp_in.file_offset = pos_ff;
                  end
               endcase
            end
         end
         S_READ_STEP: begin
            rsp_in.read_sector   = rs_now;
            rsp_in.sector_offset = off_ff;
            rsp_in.bytes_taken   = taken_ff;
            rsp_in.load_next     = 1'b0;
            rsp_in.next_sector   = '0;
            rsp_in.chain_end     = 1'b0;
            rsp_in.file_offset   = pos_ff;
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
            if (step_ff) begin
               if (!cluster_wrap) begin
                  // Next sector of the same cluster.
                  sic_in             = ns[6:0];
                  rsp_in.load_next   = 1'b1;
                  rsp_in.next_sector = nsec_same;
               end else begin
                  sic_in = '0;
                  if (out_of_table || next_end) begin
                     // Chain ends; the current cluster stays when it lies outside the table.
                     if (!out_of_table) begin
                        cur_cluster_in = rd_data_ff;
                     end
                     if (!root_ff) begin
                        size_in = pos_ff;
                     end
                     ended_in         = 1'b1;
                     rsp_in.chain_end = 1'b1;
                  end else begin
                     // Follow the chain; the first sector address needs another multiply.
                     cur_cluster_in = rd_data_ff;
                     mul_a          = 32'(rd_data_ff) - fccr_pkg::FIRST_DATA_CLUSTER;
                     product_in     = product;
                     rs_in          = rs_now;
                     rsp_valid_in   = 1'b0;
                     state_in       = S_EMIT_NEXT;
                  end
               end
            end
         end
         S_EMIT_NEXT: begin
            // Sector zero of a newly entered cluster is the one to fetch.
            rsp_in.read_sector   = rs_ff;
            rsp_in.sector_offset = off_ff;
            rsp_in.bytes_taken   = taken_ff;
            rsp_in.load_next     = 1'b1;
            rsp_in.next_sector   = cfg.base_sector + product_ff;
            rsp_in.chain_end     = ended_ff;
            rsp_in.file_offset   = pos_ff;
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and file state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cur_cluster_ff <= '0;
         sic_ff         <= '0;
         pos_ff         <= '0;
         size_ff        <= '0;
         dir_ff         <= 1'b0;
         root_ff        <= 1'b0;
         ended_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_cluster_ff <= cur_cluster_in;
         sic_ff         <= sic_in;
         pos_ff         <= pos_in;
         size_ff        <= size_in;
         dir_ff         <= dir_in;
         root_ff        <= root_in;
         ended_ff       <= ended_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working registers and the result beat carry payload only.
   always_ff @(posedge clock) begin
      product_ff <= product_in;
      taken_ff   <= taken_in;
      off_ff     <= off_in;
      step_ff    <= step_in;
      rs_ff      <= rs_in;
      rsp_ff     <= rsp_in;
   end

   // Table memory: one write port for loads, one registered read at the current cluster.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_word[AW-1:0]] <= head.entry;
      end
      rd_data_ff <= table_mem[rd_word[AW-1:0]];
   end

endmodule

// ----- rtl/core/fat32_cluster_chain_reader_unit.sv -----
// Top level of the FAT32 cluster chain reader: register file, front, queue and back.
// Depends on fccr_pkg, fccr_front, fccr_queue and fccr_back.
//
//   Channel   Ports                                  Beat accepted when
//   input     start, busy, req_item                  start high and busy low
//   result    rsp_valid, rsp_item                    every cycle rsp_valid is high
//   config    csr_valid, csr_ready, csr_index, csr_data  csr_valid and csr_ready high
//
// An accepted beat enters the command queue at that edge; the idle back end pops it.
// A table load, a no-op or a read after the chain ended is answered from idle, an open
// via the emit state, a read within one cluster via the read step state, and a read
// that follows the chain via read step then emit, bound by the table read and then the
// sector multiply. busy is high while the queue is full. Reset is synchronous and does
// not clear the table. Results are strobed for one cycle and the receiver cannot stall them.
module fat32_cluster_chain_reader_unit #(
   parameter int TABLE_DEPTH = fccr_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fccr_pkg::req_type req_item,
   output logic              rsp_valid,
   output fccr_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   // Configuration registers and the derived geometry.
   logic [31:0] part_offset_ff;
   logic [31:0] data_start_ff;
   logic [7:0]  cluster_sectors_ff;
   logic [31:0] base_sector_ff;
   logic        csr_write;
   fccr_pkg::cfg_type cfg;

   // Links between the parts.
   fccr_pkg::cmd_type front_cmd;
   fccr_pkg::cmd_type head;
   logic              q_full;
   logic              head_valid;
   logic              pop;
   logic              push;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_offset_ff     <= fccr_pkg::PART_OFFSET_RESET;
         data_start_ff      <= fccr_pkg::DATA_START_RESET;
         cluster_sectors_ff <= fccr_pkg::SPC_RESET;
         base_sector_ff     <= fccr_pkg::PART_OFFSET_RESET + fccr_pkg::DATA_START_RESET;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               fccr_pkg::CSR_PART_OFFSET:     part_offset_ff     <= csr_data;
               fccr_pkg::CSR_DATA_START:      data_start_ff      <= csr_data;
               fccr_pkg::CSR_CLUSTER_SECTORS: cluster_sectors_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         base_sector_ff <= part_offset_ff + data_start_ff;
      end
   end

   // Sectors per cluster: zero acts as one, values above the maximum saturate.
   always_comb begin
      cfg.base_sector = base_sector_ff;
      if (cluster_sectors_ff < fccr_pkg::SPC_MIN) begin
         cfg.spc = fccr_pkg::SPC_MIN;
      end else if (cluster_sectors_ff > fccr_pkg::SPC_MAX) begin
         cfg.spc = fccr_pkg::SPC_MAX;
      end else begin
         cfg.spc = cluster_sectors_ff;
      end
   end

   assign busy = q_full;
   assign push = start && !busy;

   fccr_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .req_item(req_item),
      .cmd     (front_cmd)
   );

   fccr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head)
   );

   fccr_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // No result beat comes out in the cycle after a reset.
   a_quiet_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A sector fetch is never requested once the chain has ended.
   a_fetch_not_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.load_next |-> !rsp_item.chain_end)
      else $error("sector fetch with chain ended");

   // The bytes taken never run past the end of their sector.
   a_within_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (11'(rsp_item.sector_offset) + 11'(rsp_item.bytes_taken))
                    <= 11'(fccr_pkg::SECTOR_BYTES))
      else $error("chunk crosses a sector boundary");

endmodule
